// File: hw/rtl/sws_pkg.sv
// Shared constants, types and codes for the sliding-window squared distance block.
// Depends on nothing; every other file of the block imports it.
package sws_pkg;

  localparam int MAX_WINDOW  = 256;
  localparam int SAMPLE_BITS = 16;

  localparam int LEN_W    = $clog2(MAX_WINDOW + 1);
  localparam int STEP_W   = $clog2(MAX_WINDOW);
  localparam int CFG_W    = 9;
  localparam int OP_W     = 2;
  localparam int IDX_W    = 8;
  localparam int MAG_W    = SAMPLE_BITS;
  localparam int PROD_W   = 2 * MAG_W;
  localparam int DIST_W   = 40;
  localparam int SUM_W    = ((PROD_W > DIST_W) ? PROD_W : DIST_W) + 1;
  localparam int START_W  = 16;
  localparam int SERIES_W = 10;
  localparam int COUNT_W  = 17;

  localparam logic [CFG_W-1:0]  LEN_RESET = CFG_W'(64);
  localparam logic [DIST_W-1:0] DIST_MAX  = {DIST_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_DATA  = 2'd1,
    OP_START = 2'd2
  } sws_op_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic shift_in;
    logic scan_shift;
    logic rotate;
    logic ref_we;
  } sws_cell_ctrl_t;

endpackage

// File: hw/rtl/sws_if.sv
// Channel interfaces for the input, result and configuration beats.
// Depends on sws_pkg for field widths and the sample type.
interface sws_in_if import sws_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      opcode;
  logic [IDX_W-1:0]     ref_index;
  sample_t              sample;

  modport source(output valid, opcode, ref_index, sample, input ready);
  modport sink(input valid, opcode, ref_index, sample, output ready);
endinterface

interface sws_out_if import sws_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DIST_W-1:0]    distance;
  logic [START_W-1:0]   window_start;
  logic [SERIES_W-1:0]  series_index;

  modport source(output valid, distance, window_start, series_index, input ready);
  modport sink(input valid, distance, window_start, series_index, output ready);
endinterface

interface sws_cfg_if import sws_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_W-1:0]     window_len;

  modport source(output valid, window_len, input ready);
  modport sink(input valid, window_len, output ready);
endinterface

// File: hw/rtl/sws_cell.sv
// One cell of the chain: a delay-line tap, its scan copy and one reference entry.
// Depends on sws_pkg for the sample type and the control struct.
module sws_cell import sws_pkg::*; (
  input  logic           clk,
  input  sws_cell_ctrl_t ctrl,
  input  logic           ref_sel,
  input  sample_t        ref_wdata,
  input  sample_t        win_prev,
  input  sample_t        scan_next,
  input  sample_t        ref_next,
  output sample_t        win_out,
  output sample_t        scan_out,
  output sample_t        ref_out
);

  sample_t win_r, win_nxt;
  sample_t scan_r, scan_nxt;
  sample_t ref_r, ref_nxt;

  always_comb begin
    win_nxt  = win_r;
    scan_nxt = scan_r;
    ref_nxt  = ref_r;
    if (ctrl.shift_in) begin
      win_nxt  = win_prev;
      scan_nxt = win_prev;
    end else if (ctrl.scan_shift) begin
      scan_nxt = scan_next;
    end
    if (ctrl.ref_we && ref_sel) begin
      ref_nxt = ref_wdata;
    end else if (ctrl.rotate) begin
      ref_nxt = ref_next;
    end
  end

  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    scan_r <= scan_nxt;
    ref_r  <= ref_nxt;
  end

  assign win_out  = win_r;
  assign scan_out = scan_r;
  assign ref_out  = ref_r;

endmodule

// File: hw/rtl/sws_chain.sv
// Row of MAX_WINDOW cells; the reference rotates and the window scan drains toward cell 0.
// Depends on sws_pkg and sws_cell.
module sws_chain import sws_pkg::*; (
  input  logic             clk,
  input  sws_cell_ctrl_t   ctrl,
  input  logic [IDX_W-1:0] ref_idx,
  input  sample_t          din,
  output sample_t          win_tap,
  output sample_t          ref_tap
);

  sample_t win_w  [MAX_WINDOW];
  sample_t scan_w [MAX_WINDOW];
  sample_t ref_w  [MAX_WINDOW];

  for (genvar c = 0; c < MAX_WINDOW; c++) begin : g_cell
    localparam int RIDX = MAX_WINDOW - 1 - c;
    sample_t win_prev;
    sample_t scan_next;
    logic    sel;

    if (c == 0) begin : g_head
      assign win_prev = din;
    end else begin : g_body
      assign win_prev = win_w[c-1];
    end

    if (c == MAX_WINDOW - 1) begin : g_tail
      assign scan_next = '0;
    end else begin : g_inner
      assign scan_next = scan_w[c+1];
    end

    if (RIDX < (1 << IDX_W)) begin : g_sel
      assign sel = (ref_idx == IDX_W'(RIDX));
    end else begin : g_nosel
      assign sel = 1'b0;
    end

    sws_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .ref_sel   (sel),
      .ref_wdata (din),
      .win_prev  (win_prev),
      .scan_next (scan_next),
      .ref_next  (ref_w[(c + 1) % MAX_WINDOW]),
      .win_out   (win_w[c]),
      .scan_out  (scan_w[c]),
      .ref_out   (ref_w[c])
    );
  end

  assign win_tap = scan_w[0];
  assign ref_tap = ref_w[0];

endmodule

// File: hw/rtl/sws_mac.sv
// Squared-difference accumulator at the head of the chain: abs, square, saturating add.
// Depends on sws_pkg for widths.
module sws_mac import sws_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear,
  input  logic              step_valid,
  input  sample_t           win_tap,
  input  sample_t           ref_tap,
  output logic [DIST_W-1:0] acc
);

  logic signed [SAMPLE_BITS:0] diff;
  logic [MAG_W-1:0]            mag_r;
  logic [PROD_W-1:0]           prod_r;
  logic [DIST_W-1:0]           acc_r, acc_nxt;
  logic [SUM_W-1:0]            sum;
  logic                        v1_r, v2_r;

  assign diff = {win_tap[SAMPLE_BITS-1], win_tap} - {ref_tap[SAMPLE_BITS-1], ref_tap};
  assign sum  = SUM_W'(acc_r) + SUM_W'(prod_r);

  always_comb begin
    acc_nxt = acc_r;
    if (clear) begin
      acc_nxt = '0;
    end else if (v2_r) begin
      acc_nxt = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= step_valid;
      v2_r <= v1_r;
    end
    mag_r  <= diff[SAMPLE_BITS] ? MAG_W'(-diff) : MAG_W'(diff);
    prod_r <= PROD_W'(mag_r) * PROD_W'(mag_r);
    acc_r  <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// File: hw/rtl/sliding_window_squared_distance.sv
// Distance profile engine. Load beats, start beats and data beats that produce no result
// leave the engine idle and ready for the next beat. A data beat that completes a window holds
// off the next beat while the reference rotates once around the cell chain, one cell per cycle,
// past the single multiply-accumulate at cell 0, followed by a two-stage flush and the result
// load; the result load waits while the previous result has not yet been taken.
// Depends on sws_pkg, sws_if, sws_chain and sws_mac.
module sliding_window_squared_distance import sws_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  sws_in_if.sink  in_ch,
  sws_out_if.source out_ch,
  sws_cfg_if.sink cfg_ch
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH1,
    ST_FLUSH2,
    ST_DONE
  } state_t;

  state_t               state_r;
  logic [CFG_W-1:0]     window_len_r;
  logic [COUNT_W-1:0]   count_r;
  logic [SERIES_W-1:0]  series_r;
  logic                 seen_r;
  logic [STEP_W-1:0]    step_r;
  logic [STEP_W-1:0]    skip_r;
  logic [START_W-1:0]   meta_start_r;
  logic [SERIES_W-1:0]  meta_series_r;
  logic                 out_valid_r;
  logic [DIST_W-1:0]    out_dist_r;
  logic [START_W-1:0]   out_start_r;
  logic [SERIES_W-1:0]  out_series_r;

  logic [LEN_W-1:0]     eff_len;
  logic [STEP_W-1:0]    skip;
  logic [COUNT_W-1:0]   count_inc;
  logic [COUNT_W-1:0]   start_raw;
  logic [START_W-1:0]   start_val;
  logic                 in_acc;
  logic                 data_ok;
  logic                 need_result;
  logic                 load_result;
  sws_cell_ctrl_t       ctrl;
  sample_t              win_tap;
  sample_t              ref_tap;
  logic [DIST_W-1:0]    acc;

  always_comb begin
    if (window_len_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (int'(window_len_r) > MAX_WINDOW) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = LEN_W'(window_len_r);
    end
  end

  assign skip        = STEP_W'(LEN_W'(MAX_WINDOW) - eff_len);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign data_ok     = in_acc && (in_ch.opcode == OP_DATA) && seen_r;
  assign count_inc   = (count_r == '1) ? count_r : count_r + COUNT_W'(1);
  assign need_result = data_ok && (count_inc >= COUNT_W'(eff_len));
  assign start_raw   = count_inc - COUNT_W'(eff_len);
  assign start_val   = (start_raw > COUNT_W'({START_W{1'b1}})) ? '1 : START_W'(start_raw);
  assign load_result = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  assign ctrl.shift_in   = data_ok;
  assign ctrl.ref_we     = in_acc && (in_ch.opcode == OP_LOAD);
  assign ctrl.rotate     = (state_r == ST_RUN);
  assign ctrl.scan_shift = (state_r == ST_RUN) && (step_r >= skip_r);

  sws_chain u_chain (
    .clk     (clk),
    .ctrl    (ctrl),
    .ref_idx (in_ch.ref_index),
    .din     (in_ch.sample),
    .win_tap (win_tap),
    .ref_tap (ref_tap)
  );

  sws_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (need_result),
    .step_valid (ctrl.scan_shift),
    .win_tap    (win_tap),
    .ref_tap    (ref_tap),
    .acc        (acc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      window_len_r  <= LEN_RESET;
      count_r       <= '0;
      series_r      <= '0;
      seen_r        <= 1'b0;
      step_r        <= '0;
      skip_r        <= '0;
      meta_start_r  <= '0;
      meta_series_r <= '0;
      out_valid_r   <= 1'b0;
      out_dist_r    <= '0;
      out_start_r   <= '0;
      out_series_r  <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        window_len_r <= cfg_ch.window_len;
      end
      if (load_result) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_ch.opcode)
              OP_START: begin
                if (seen_r) begin
                  if (series_r != '1) begin
                    series_r <= series_r + SERIES_W'(1);
                  end
                end else begin
                  seen_r <= 1'b1;
                end
                count_r <= '0;
              end
              OP_DATA: begin
                if (seen_r) begin
                  count_r <= count_inc;
                end
                if (need_result) begin
                  state_r       <= ST_RUN;
                  step_r        <= '0;
                  skip_r        <= skip;
                  meta_start_r  <= start_val;
                  meta_series_r <= series_r;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_RUN: begin
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(MAX_WINDOW - 1)) begin
            state_r <= ST_FLUSH1;
          end
        end
        ST_FLUSH1: begin
          state_r <= ST_FLUSH2;
        end
        ST_FLUSH2: begin
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (load_result) begin
            out_dist_r   <= acc;
            out_start_r  <= meta_start_r;
            out_series_r <= meta_series_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.distance     = out_dist_r;
  assign out_ch.window_start = out_start_r;
  assign out_ch.series_index = out_series_r;

endmodule

// File: hw/rtl/sws_checker.sv
// Port-level checks for the distance profile engine and the bind that attaches them.
// Depends on sws_pkg and the top level sliding_window_squared_distance.
module sws_checker import sws_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [OP_W-1:0]     in_opcode,
  input logic                out_valid,
  input logic                out_ready,
  input logic [DIST_W-1:0]   out_distance,
  input logic [START_W-1:0]  out_window_start,
  input logic [SERIES_W-1:0] out_series_index
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result beat was withdrawn before it was taken.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_distance) && $stable(out_window_start)
      && $stable(out_series_index))
    else $error("Result payload changed while the beat was stalled.");

  a_short_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode != OP_DATA) |=> in_ready)
    else $error("A load or start beat blocked the input channel.");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("A result appeared without a preceding distance pass.");

endmodule

bind sliding_window_squared_distance sws_checker u_sws_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_opcode        (in_ch.opcode),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_distance     (out_ch.distance),
  .out_window_start (out_ch.window_start),
  .out_series_index (out_ch.series_index)
);
